FILE: design/rvn_pkg.sv
`timescale 1ns / 1ps

package rvn_pkg;

   // Vector store depth and data widths
   localparam int MAX_DIM  = 16;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = $clog2(MAX_DIM + 1);
   localparam int ADDR_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int SHIFT_W  = $clog2(DATA_W);
   localparam int STATUS_W = 2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

   typedef logic [DATA_W-1:0] data_type;

   // Request into the shared divider
   typedef struct packed {
      logic     start;
      data_type dividend;
      data_type divisor;
   } div_req_type;

   // Status and result out of the shared divider
   typedef struct packed {
      logic     busy;
      logic     done;
      data_type quotient;
   } div_rsp_type;

endpackage

FILE: design/rvn_stream_if.sv
`timescale 1ns / 1ps

// Input item channel: one numerator per item
interface rvn_req_if import rvn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] numerator;
   logic        [DATA_W-1:0] denominator;
   logic                     last;

   modport source (output valid, numerator, denominator, last, input ready);
   modport sink   (input valid, numerator, denominator, last, output ready);
endinterface

// Result item channel: one reduced element per item
interface rvn_rsp_if import rvn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] reduced_numerator;
   logic        [DATA_W-1:0] reduced_denominator;
   logic      [STATUS_W-1:0] status;
   logic                     end_of_vector;

   modport source (output valid, reduced_numerator, reduced_denominator, status,
                   end_of_vector, input ready);
   modport sink   (input valid, reduced_numerator, reduced_denominator, status,
                   end_of_vector, output ready);
endinterface

FILE: design/rvn_ram.sv
`timescale 1ns / 1ps

module rvn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    we,
   input  logic [AW-1:0]           waddr,
   input  logic [WIDTH-1:0]        wdata,
   input  logic [AW-1:0]           raddr,
   output logic [WIDTH-1:0]        rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/rvn_divider.sv
`timescale 1ns / 1ps

module rvn_divider import rvn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SHIFT_W-1:0] count_ff, count_in;
   data_type           rem_ff, rem_in;
   data_type           quo_ff, quo_in;
   data_type           divisor_ff, divisor_in;

   logic [DATA_W:0]    shifted;
   logic [DATA_W:0]    diff;
   logic               fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, divisor_ff};
      fits    = shifted >= {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;

      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         quo_in   = {quo_ff[DATA_W-2:0], fits};
         count_in = count_ff + SHIFT_W'(1);
         if (count_ff == SHIFT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: design/rational_vector_normalize.sv
`timescale 1ns / 1ps

// Reduces a rational vector to lowest terms. Numerators stream in one per item; the
// denominator is taken from the first item of a vector. Each item is accepted in idle
// and, for a nonzero numerator, folded into the running gcd by a binary gcd pass (one
// shift or subtract per cycle). On the item marked last the block divides the
// denominator and then each stored element by the gcd on one shared restoring divider,
// one element at a time, with elements read back from a synchronous store. No item is
// taken while a vector is being emitted. A zero denominator gives one result with
// status 1; otherwise more than MAX_DIM elements gives one result with status 2.
module rational_vector_normalize import rvn_pkg::*; (
   input logic      clock,
   input logic      reset,
   rvn_req_if.sink  req_ch,
   rvn_rsp_if.source rsp_ch
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_GCD    = 4'd1;
   localparam logic [3:0] S_CHECK  = 4'd2;
   localparam logic [3:0] S_DENDIV = 4'd3;
   localparam logic [3:0] S_READ   = 4'd4;
   localparam logic [3:0] S_LOAD   = 4'd5;
   localparam logic [3:0] S_NUMDIV = 4'd6;
   localparam logic [3:0] S_EMIT   = 4'd7;
   localparam logic [3:0] S_ERR    = 4'd8;

   logic [3:0]          state_ff, state_in;
   data_type            running_ff, running_in;
   data_type            held_ff, held_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic                last_ff, last_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   data_type            gu_ff, gu_in;
   data_type            gv_ff, gv_in;
   logic [SHIFT_W-1:0]  gk_ff, gk_in;
   data_type            rden_ff, rden_in;
   data_type            quo_ff, quo_in;
   logic                sign_ff, sign_in;

   logic                rsp_valid_ff, rsp_valid_in;
   data_type            rsp_num_ff, rsp_num_in;
   data_type            rsp_den_ff, rsp_den_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_eov_ff, rsp_eov_in;

   logic                accept;
   logic                first;
   logic                room;
   data_type            base;
   data_type            num_u;
   data_type            num_mag;
   data_type            elem_mag;
   logic                slot_free;
   logic                rsp_load;
   logic [CNT_W-1:0]    last_idx;

   logic                ram_we;
   data_type            ram_rdata;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // Element store
   rvn_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_DIM)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(count_ff[ADDR_W-1:0]),
      .wdata(num_u),
      .raddr(idx_ff[ADDR_W-1:0]),
      .rdata(ram_rdata)
   );

   // Shared divider for the denominator and every element
   rvn_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign first        = (count_ff == '0) && !ovf_ff;
   assign room         = count_ff < CNT_W'(MAX_DIM);
   assign base         = first ? req_ch.denominator : running_ff;
   assign num_u        = data_type'(req_ch.numerator);
   assign num_mag      = num_u[DATA_W-1] ? data_type'('0) - num_u : num_u;
   assign elem_mag     = ram_rdata[DATA_W-1] ? data_type'('0) - ram_rdata : ram_rdata;
   assign ram_we       = accept && room;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign last_idx     = count_ff - CNT_W'(1);

   // Sequence absorb, gcd, and the output pass
   always_comb begin
      state_in      = state_ff;
      running_in    = running_ff;
      held_in       = held_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      gu_in         = gu_ff;
      gv_in         = gv_ff;
      gk_in         = gk_ff;
      rden_in       = rden_ff;
      quo_in        = quo_ff;
      sign_in       = sign_ff;
      rsp_load      = 1'b0;
      rsp_num_in    = rsp_num_ff;
      rsp_den_in    = rsp_den_ff;
      rsp_status_in = rsp_status_ff;
      rsp_eov_in    = rsp_eov_ff;
      div_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in = req_ch.last;
               if (first) begin
                  held_in    = req_ch.denominator;
                  running_in = req_ch.denominator;
               end
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
                  if (num_u != '0) begin
                     gu_in    = base;
                     gv_in    = num_mag;
                     gk_in    = '0;
                     state_in = S_GCD;
                  end else if (req_ch.last) begin
                     state_in = S_CHECK;
                  end
               end else begin
                  ovf_in = 1'b1;
                  if (req_ch.last) begin
                     state_in = S_CHECK;
                  end
               end
            end
         end
         S_GCD: begin
            // One binary gcd step per cycle
            if (gu_ff == '0) begin
               running_in = gv_ff << gk_ff;
               state_in   = last_ff ? S_CHECK : S_IDLE;
            end else if (!gu_ff[0] && !gv_ff[0]) begin
               gu_in = gu_ff >> 1;
               gv_in = gv_ff >> 1;
               gk_in = gk_ff + SHIFT_W'(1);
            end else if (!gu_ff[0]) begin
               gu_in = gu_ff >> 1;
            end else if (!gv_ff[0]) begin
               gv_in = gv_ff >> 1;
            end else if (gu_ff >= gv_ff) begin
               gu_in = (gu_ff - gv_ff) >> 1;
            end else begin
               gv_in = (gv_ff - gu_ff) >> 1;
            end
         end
         S_CHECK: begin
            if (held_ff == '0 || ovf_ff) begin
               state_in = S_ERR;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = held_ff;
               div_req.divisor  = running_ff;
               state_in         = S_DENDIV;
            end
         end
         S_DENDIV: begin
            if (div_rsp.done) begin
               rden_in  = div_rsp.quotient;
               idx_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            sign_in          = ram_rdata[DATA_W-1];
            div_req.start    = 1'b1;
            div_req.dividend = elem_mag;
            div_req.divisor  = running_ff;
            state_in         = S_NUMDIV;
         end
         S_NUMDIV: begin
            if (div_rsp.done) begin
               quo_in   = div_rsp.quotient;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_num_in    = sign_ff ? data_type'('0) - quo_ff : quo_ff;
               rsp_den_in    = rden_ff;
               rsp_status_in = STATUS_OK;
               rsp_eov_in    = (idx_ff == last_idx);
               if (idx_ff == last_idx) begin
                  running_in = '0;
                  held_in    = '0;
                  count_in   = '0;
                  ovf_in     = 1'b0;
                  last_in    = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_READ;
               end
            end
         end
         S_ERR: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_num_in    = '0;
               rsp_den_in    = '0;
               rsp_status_in = (held_ff == '0) ? STATUS_ZERO_DEN : STATUS_TOO_LONG;
               rsp_eov_in    = 1'b1;
               running_in    = '0;
               held_in       = '0;
               count_in      = '0;
               ovf_in        = 1'b0;
               last_in       = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Hold the result until taken
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= '0;
         held_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         held_ff      <= held_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      gu_ff         <= gu_in;
      gv_ff         <= gv_in;
      gk_ff         <= gk_in;
      rden_ff       <= rden_in;
      quo_ff        <= quo_in;
      sign_ff       <= sign_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_den_ff    <= rsp_den_in;
      rsp_status_ff <= rsp_status_in;
      rsp_eov_ff    <= rsp_eov_in;
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.reduced_numerator   = $signed(rsp_num_ff);
   assign rsp_ch.reduced_denominator = rsp_den_ff;
   assign rsp_ch.status              = rsp_status_ff;
   assign rsp_ch.end_of_vector       = rsp_eov_ff;

   // Store fill never passes its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DIM))
      else $error("element count past store depth");

   // Divider is never restarted while it works
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // Divisions only run against a nonzero gcd
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD || state_ff == S_CHECK && held_ff != '0) |-> running_ff != '0)
      else $error("division by zero gcd");

   // Error results always close the vector
   a_err_eov: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != STATUS_OK) |-> rsp_ch.end_of_vector)
      else $error("error result without end of vector");

   // A good result never carries a zero denominator
   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == STATUS_OK) |-> rsp_ch.reduced_denominator != '0)
      else $error("ok result with zero denominator");

endmodule

FILE: tb/tb_rational_vector_normalize.sv
`timescale 1ns / 1ps

module tb_rational_vector_normalize;
   import rvn_pkg::*;

   // One numerator as sent on the request channel
   typedef struct {
      data_type numerator;
      data_type denominator;
      logic     last;
   } element_type;

   // One reduced element as expected on the result channel
   typedef struct {
      data_type              numerator;
      data_type              denominator;
      logic [STATUS_W-1:0]   status;
      logic                  end_of_vector;
   } reduced_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rvn_req_if req_ch ();
   rvn_rsp_if rsp_ch ();

   rational_vector_normalize i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Numerators waiting to be sent, and reduced elements waiting to arrive
   element_type pending_q [$];
   reduced_type reduced_q [$];
   data_type    draft_nums [$];

   // Shadow of the vector under reduction
   data_type    stored_num [MAX_DIM];
   data_type    gcd_acc = '0;
   data_type    den_hold = '0;
   int unsigned elem_count = 0;
   bit          overflow_flag = 1'b0;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned send_idle_by_phase [4] = '{0, 85, 0, 15};
   int unsigned rsp_stall_by_phase [4] = '{0, 0, 85, 15};
   int unsigned error_count = 0;

   element_type next_elem;
   reduced_type want;

   // Clock: 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Euclid on unsigned 32-bit values
   function automatic data_type gcd_of(data_type a, data_type b);
      data_type r;
      while (b != '0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   function automatic data_type magnitude_of(data_type v);
      return v[DATA_W-1] ? data_type'('0) - v : v;
   endfunction

   // Fold one accepted numerator into the shadow state; on the last one, queue
   // the reduced elements (or the single error result)
   function automatic void absorb_numerator(data_type num, data_type den, logic last);
      reduced_type r;
      data_type    q;
      if (elem_count == 0 && !overflow_flag) begin
         den_hold = den;
         gcd_acc  = den;
      end
      if (elem_count < MAX_DIM) begin
         stored_num[elem_count] = num;
         elem_count++;
         if (num != '0)
            gcd_acc = gcd_of(gcd_acc, magnitude_of(num));
      end else begin
         overflow_flag = 1'b1;
      end
      if (!last)
         return;
      if (den_hold == '0 || overflow_flag) begin
         r.numerator     = '0;
         r.denominator   = '0;
         r.status        = (den_hold == '0) ? STATUS_ZERO_DEN : STATUS_TOO_LONG;
         r.end_of_vector = 1'b1;
         reduced_q.push_back(r);
      end else begin
         for (int unsigned i = 0; i < elem_count; i++) begin
            q = magnitude_of(stored_num[i]) / gcd_acc;
            if (stored_num[i][DATA_W-1])
               q = data_type'('0) - q;
            r.numerator     = q;
            r.denominator   = den_hold / gcd_acc;
            r.status        = STATUS_OK;
            r.end_of_vector = (i + 1 == elem_count);
            reduced_q.push_back(r);
         end
      end
      gcd_acc       = '0;
      den_hold      = '0;
      elem_count    = 0;
      overflow_flag = 1'b0;
   endfunction

   // Turn draft_nums into one vector of items; later items carry noise denominators
   task automatic send_vector(input data_type den);
      element_type e;
      for (int i = 0; i < draft_nums.size(); i++) begin
         e.numerator   = draft_nums[i];
         e.denominator = (i == 0) ? den : data_type'($urandom());
         e.last        = (i == draft_nums.size() - 1);
         pending_q.push_back(e);
      end
      draft_nums.delete();
   endtask

   // Build one random vector, mostly with a shared factor so the gcd is nontrivial
   task automatic queue_random_vector(output int unsigned n_items);
      int unsigned sel, len, pick;
      data_type    g, den, mag;
      bit          zero_den, too_long;
      sel      = $urandom_range(99);
      zero_den = (sel < 8) || (sel >= 16 && sel < 20);
      too_long = (sel >= 8 && sel < 20);
      if (too_long)
         len = $urandom_range(MAX_DIM + 4, MAX_DIM + 1);
      else if ($urandom_range(3) == 0)
         len = $urandom_range(3, 1);
      else
         len = $urandom_range(MAX_DIM, 1);
      pick = $urandom_range(3);
      if (pick == 0)
         g = 1;
      else if (pick == 1)
         g = data_type'(1) << $urandom_range(30);
      else if (pick == 2)
         g = $urandom_range(1000, 2);
      else
         g = $urandom_range(65535, 2);
      if (zero_den)
         den = '0;
      else if (g == 1)
         den = $urandom();
      else
         den = g * data_type'($urandom_range(32'hFFFF_FFFF / g, 1));
      for (int unsigned i = 0; i < len; i++) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            draft_nums.push_back('0);
         end else if (g == 1) begin
            draft_nums.push_back((pick == 1) ? 32'h8000_0000 : data_type'($urandom()));
         end else begin
            mag = g * data_type'($urandom_range(32'h7FFF_FFFF / g, 0));
            draft_nums.push_back($urandom_range(1) ? data_type'('0) - mag : mag);
         end
      end
      send_vector(den);
      n_items = len;
   endtask

   // Hold until every item is taken and every reduced element has arrived
   task automatic wait_drained();
      while (pending_q.size() != 0 || req_ch.valid || reduced_q.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: predict on acceptance, then present the next item
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            absorb_numerator(req_ch.numerator, req_ch.denominator, req_ch.last);
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_elem = pending_q.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.numerator   <= next_elem.numerator;
               req_ch.denominator <= next_elem.denominator;
               req_ch.last        <= next_elem.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each accepted item with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (reduced_q.size() == 0) begin
               $error("unexpected result: numerator %0d, denominator %0d, status %0d",
                      $signed(rsp_ch.reduced_numerator), rsp_ch.reduced_denominator,
                      rsp_ch.status);
               error_count++;
            end else begin
               want = reduced_q.pop_front();
               if (rsp_ch.reduced_numerator !== want.numerator) begin
                  $error("reduced_numerator: expected %0d, actual %0d",
                         $signed(want.numerator), $signed(rsp_ch.reduced_numerator));
                  error_count++;
               end
               if (rsp_ch.reduced_denominator !== want.denominator) begin
                  $error("reduced_denominator: expected %0d, actual %0d",
                         want.denominator, rsp_ch.reduced_denominator);
                  error_count++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                  error_count++;
               end
               if (rsp_ch.end_of_vector !== want.end_of_vector) begin
                  $error("end_of_vector: expected %0d, actual %0d",
                         want.end_of_vector, rsp_ch.end_of_vector);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Stimulus: directed vectors, then random vectors under each idling mix
   initial begin
      int unsigned phase_items, n;
      req_ch.valid       = 1'b0;
      req_ch.numerator   = '0;
      req_ch.denominator = '0;
      req_ch.last        = 1'b0;
      rsp_ch.ready       = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // shared factor of two, with a zero element
      draft_nums = '{32'd4, -32'sd8, 32'd0};
      send_vector(32'd6);
      // most negative numerator over 2^31
      draft_nums = '{32'h8000_0000};
      send_vector(32'h8000_0000);
      // largest denominator with the extreme numerators
      draft_nums = '{32'h7FFF_FFFF, 32'h8000_0001};
      send_vector(32'hFFFF_FFFF);
      // zero denominator
      draft_nums = '{32'd5};
      send_vector(32'd0);
      // all numerators zero: the gcd is the denominator itself
      draft_nums = '{32'd0};
      send_vector(32'd7);
      // already in lowest terms
      draft_nums = '{32'd1};
      send_vector(32'd1);
      // one element more than the store holds
      for (int i = 0; i <= MAX_DIM; i++)
         draft_nums.push_back(data_type'(3 * (i + 1)));
      send_vector(32'd3);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_idle_by_phase[phase];
         rsp_stall_pct = rsp_stall_by_phase[phase];
         phase_items   = 0;
         while (phase_items < 90) begin
            queue_random_vector(n);
            phase_items += n;
         end
         // sender stays quiet until the whole phase has drained
         wait_drained();
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (200) @(negedge clock);
      if (error_count == 0)
         $display("rational_vector_normalize test passed");
      else
         $display("rational_vector_normalize test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #8_000_000;
      $display("rational_vector_normalize test failed");
      $finish;
   end

endmodule

FILE: rational_vector_normalize.f
design/rvn_pkg.sv
design/rvn_stream_if.sv
design/rvn_ram.sv
design/rvn_divider.sv
design/rational_vector_normalize.sv
tb/tb_rational_vector_normalize.sv
